>>> rtl/cgb_pkg.sv
// Shared types and constants for the gap-buffer text editor.
// Used by the controller, the datapath and the top level; depends on nothing.
package cgb_pkg;

  // Command codes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LEFT   = 3'd1;
  localparam logic [2:0] OP_RIGHT  = 3'd2;
  localparam logic [2:0] OP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EDGE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned LEN_W = 11;

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       char_in;
    logic [IDX_W-1:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       char_out;
    logic [LEN_W-1:0] text_length;
    logic [LEN_W-1:0] cursor_pos;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture the accepted command
    logic exec;  // perform a one-step command, or issue the memory read
    logic fin;   // complete a command whose memory read has returned
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_read;  // current command must read the memory first
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

>>> rtl/cursor_text_gap_buffer_top.sv
// Gap-buffer text editor: one command beat in, one result beat out.
// Insert, backspace and rejected commands complete in EXEC; cursor moves and reads issue a read
// there and complete in FIN once the registered read port returns, ahead of the write or capture.
// The result sits in an output register, so a new command is taken while it waits.
// Reset clears the cursor counts, the sequencer and the output valid; memory is not cleared.
module cursor_text_gap_buffer_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cgb_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cgb_pkg::res_t out_data
);

  cgb_pkg::ctl_t  ctl;
  cgb_pkg::stat_t stat;

  cgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  cgb_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/cgb_ctrl.sv
// Command sequencer for the gap-buffer text editor.
// Depends on cgb_pkg; drives the datapath through cgb_pkg::ctl_t.
module cgb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cgb_pkg::stat_t stat,
  output cgb_pkg::ctl_t  ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // A read can be issued at once; a finished result waits for the output slot.
        if (stat.need_read) begin
          ctl.exec  = 1'b1;
          state_nxt = S_FIN;
        end else if (stat.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cgb_dpath.sv
// Datapath of the gap-buffer text editor: text memory, cursor counts and result register.
// Depends on cgb_pkg; sequenced by cgb_ctrl through cgb_pkg::ctl_t.
module cgb_dpath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cgb_pkg::cmd_t  in_data,
  input  cgb_pkg::ctl_t  ctl,
  output cgb_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_stall,
  output cgb_pkg::res_t  out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > cgb_pkg::LEN_W) ? CW : cgb_pkg::LEN_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data_r;
  cgb_pkg::cmd_t cmd_r;
  logic [CW-1:0] before_r, before_nxt;
  logic [CW-1:0] after_r, after_nxt;
  logic          out_valid_r;
  cgb_pkg::res_t res_r;

  logic [XW-1:0] bef_x, aft_x, len_x, len_nxt_x, bef_nxt_x, idx_x, addr_x;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_char;
  logic          need_read;
  logic          rd_en, wr_en, issue, step, load_out;
  cgb_pkg::res_t res_nxt;

  assign bef_x     = XW'(before_r);
  assign aft_x     = XW'(after_r);
  assign len_x     = bef_x + aft_x;
  assign idx_x     = XW'(cmd_r.read_index);
  assign bef_nxt_x = XW'(before_nxt);
  assign len_nxt_x = bef_nxt_x + XW'(after_nxt);

  always_comb begin
    need_read = 1'b0;
    case (cmd_r.mode)
      cgb_pkg::OP_LEFT:  need_read = (before_r != '0);
      cgb_pkg::OP_RIGHT: need_read = (after_r != '0);
      cgb_pkg::OP_READ:  need_read = (idx_x < len_x);
      default:           need_read = 1'b0;
    endcase
  end
  assign stat.need_read = need_read;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign issue = ctl.exec && need_read;
  assign step  = ctl.exec && !need_read;

  // Read address: the character left of the gap, right of the gap, or at a text position.
  always_comb begin
    case (cmd_r.mode)
      cgb_pkg::OP_LEFT:  addr_x = bef_x - XW'(1);
      cgb_pkg::OP_RIGHT: addr_x = CAP_X - aft_x;
      default: begin
        if (idx_x < bef_x) begin
          addr_x = idx_x;
        end else begin
          addr_x = idx_x + (CAP_X - len_x);
        end
      end
    endcase
  end
  assign rd_addr = addr_x[AW-1:0];
  assign rd_en   = issue;

  always_comb begin
    before_nxt       = before_r;
    after_nxt        = after_r;
    wr_en            = 1'b0;
    wr_addr          = before_r[AW-1:0];
    wr_char          = cmd_r.char_in;
    res_nxt.status   = cgb_pkg::ST_DONE;
    res_nxt.char_out = '0;
    if (step) begin
      case (cmd_r.mode)
        cgb_pkg::OP_INSERT: begin
          if (len_x >= CAP_X) begin
            res_nxt.status = cgb_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            before_nxt = before_r + CW'(1);
          end
        end
        cgb_pkg::OP_LEFT:  res_nxt.status = cgb_pkg::ST_EDGE;
        cgb_pkg::OP_RIGHT: res_nxt.status = cgb_pkg::ST_EDGE;
        cgb_pkg::OP_BACK: begin
          if (before_r == '0) begin
            res_nxt.status = cgb_pkg::ST_EDGE;
          end else begin
            before_nxt = before_r - CW'(1);
          end
        end
        cgb_pkg::OP_READ:  res_nxt.status = cgb_pkg::ST_RANGE;
        default: begin
        end
      endcase
    end else if (ctl.fin) begin
      case (cmd_r.mode)
        cgb_pkg::OP_LEFT: begin
          // The character left of the gap moves to just below the tail.
          wr_en      = 1'b1;
          wr_addr    = AW'(CAP_X - aft_x - XW'(1));
          wr_char    = rd_data_r;
          before_nxt = before_r - CW'(1);
          after_nxt  = after_r + CW'(1);
        end
        cgb_pkg::OP_RIGHT: begin
          wr_en      = 1'b1;
          wr_char    = rd_data_r;
          before_nxt = before_r + CW'(1);
          after_nxt  = after_r - CW'(1);
        end
        cgb_pkg::OP_READ:  res_nxt.char_out = rd_data_r;
        default: begin
        end
      endcase
    end
    res_nxt.text_length = len_nxt_x[cgb_pkg::LEN_W-1:0];
    res_nxt.cursor_pos  = bef_nxt_x[cgb_pkg::LEN_W-1:0];
  end

  assign load_out = step || ctl.fin;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_char;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data;
    end
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_r    <= '0;
      after_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      before_r <= before_nxt;
      after_r  <= after_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_x <= CAP_X)
    else $error("text length exceeds capacity");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_nxt.status == cgb_pkg::ST_FULL) |-> (len_x == CAP_X))
    else $error("buffer full reported below capacity");

  a_insert_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cmd_r.mode == cgb_pkg::OP_INSERT && len_x < CAP_X)
    |=> (before_r == $past(before_r) + CW'(1)))
    else $error("insert did not advance the cursor");

  a_fin_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> (need_read && !ctl.exec))
    else $error("completion without a pending memory read");

endmodule

>>> dv/tb_cursor_text_gap_buffer_top.sv
// Self-checking testbench for the gap-buffer text editor, cursor_text_gap_buffer_top.
// A directed command table and random edit sessions are run; results are checked against
// typed rows or an in-bench predictor. It depends on cgb_pkg and the top level only.
module tb_cursor_text_gap_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP         = 1024;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          HOLD_AT     = 400;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          TOTAL_ITEMS = 1950;

  // Mode codes with no command behind them.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef struct {
    cgb_pkg::cmd_t cmd;
    bit            typed;
    cgb_pkg::res_t want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  cgb_pkg::cmd_t in_data;
  logic          out_valid;
  logic          out_stall;
  cgb_pkg::res_t out_data;

  // Editor image kept by the predictor.
  logic [7:0]  text_mem [0:CAP-1];
  int unsigned head_cnt;
  int unsigned tail_cnt;

  cgb_pkg::res_t expected_q[$];
  stim_row_t     directed_q[$];
  int            bad_beats;
  int            idle_cycles;
  int            items_sent;
  int            results_taken;
  bit            tx_quiet;
  bit            rx_quiet;

  cursor_text_gap_buffer_top #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one command to the editor image and returns the result it should give.
  task automatic edit_image(input cgb_pkg::cmd_t c, output cgb_pkg::res_t r);
    int unsigned len;
    logic [1:0]  st;
    logic [7:0]  rd;
    len = head_cnt + tail_cnt;
    st  = cgb_pkg::ST_DONE;
    rd  = 8'd0;
    case (c.mode)
      cgb_pkg::OP_INSERT: begin
        if (len >= CAP) begin
          st = cgb_pkg::ST_FULL;
        end else begin
          text_mem[head_cnt] = c.char_in;
          head_cnt++;
        end
      end
      cgb_pkg::OP_LEFT: begin
        if (head_cnt == 0) begin
          st = cgb_pkg::ST_EDGE;
        end else begin
          head_cnt--;
          text_mem[CAP - tail_cnt - 1] = text_mem[head_cnt];
          tail_cnt++;
        end
      end
      cgb_pkg::OP_RIGHT: begin
        if (tail_cnt == 0) begin
          st = cgb_pkg::ST_EDGE;
        end else begin
          text_mem[head_cnt] = text_mem[CAP - tail_cnt];
          head_cnt++;
          tail_cnt--;
        end
      end
      cgb_pkg::OP_BACK: begin
        if (head_cnt == 0) st = cgb_pkg::ST_EDGE;
        else head_cnt--;
      end
      cgb_pkg::OP_READ: begin
        if (c.read_index >= len) st = cgb_pkg::ST_RANGE;
        else if (c.read_index < head_cnt) rd = text_mem[c.read_index];
        else rd = text_mem[CAP - tail_cnt + (c.read_index - head_cnt)];
      end
      default: ;
    endcase
    r.status      = st;
    r.char_out    = rd;
    r.text_length = cgb_pkg::LEN_W'(head_cnt + tail_cnt);
    r.cursor_pos  = cgb_pkg::LEN_W'(head_cnt);
  endtask

  function automatic stim_row_t mk_row(logic [2:0] m, logic [7:0] ch,
                                       logic [cgb_pkg::IDX_W-1:0] idx,
                                       bit typed, logic [1:0] st, logic [7:0] co,
                                       int len, int cur);
    stim_row_t row;
    row.cmd.mode         = m;
    row.cmd.char_in      = ch;
    row.cmd.read_index   = idx;
    row.typed            = typed;
    row.want.status      = st;
    row.want.char_out    = co;
    row.want.text_length = cgb_pkg::LEN_W'(len);
    row.want.cursor_pos  = cgb_pkg::LEN_W'(cur);
    return row;
  endfunction

  task automatic add_row(input stim_row_t row);
    directed_q.insert(directed_q.size(), row);
  endtask

  // Weights are percentages; whatever is left over goes to the unused mode codes.
  function automatic cgb_pkg::cmd_t pick_cmd(int w_ins, int w_left, int w_right, int w_back,
                                             int w_read);
    cgb_pkg::cmd_t c;
    int            roll;
    int unsigned   len;
    len  = head_cnt + tail_cnt;
    roll = $urandom_range(0, 99);
    c.char_in = 8'($urandom_range(0, 255));
    if (len > 0 && $urandom_range(0, 9) < 7)
      c.read_index = cgb_pkg::IDX_W'($urandom_range(0, len - 1));
    else c.read_index = cgb_pkg::IDX_W'($urandom_range(0, CAP - 1));
    if (roll < w_ins) c.mode = cgb_pkg::OP_INSERT;
    else if (roll < w_ins + w_left) c.mode = cgb_pkg::OP_LEFT;
    else if (roll < w_ins + w_left + w_right) c.mode = cgb_pkg::OP_RIGHT;
    else if (roll < w_ins + w_left + w_right + w_back) c.mode = cgb_pkg::OP_BACK;
    else if (roll < w_ins + w_left + w_right + w_back + w_read) c.mode = cgb_pkg::OP_READ;
    else c.mode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return c;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Offers one command beat, waits for it to be taken and records its expected result.
  task automatic send_cmd(input cgb_pkg::cmd_t c, input bit typed, input cgb_pkg::res_t want);
    int            gap;
    cgb_pkg::res_t pred;
    if (items_sent % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edit_image(c, pred);
    expected_q.insert(expected_q.size(), typed ? want : pred);
    items_sent++;
  endtask

  task automatic send_random(int w_ins, int w_left, int w_right, int w_back, int w_read);
    send_cmd(pick_cmd(w_ins, w_left, w_right, w_back, w_read), 1'b0, '0);
  endtask

  task automatic flag_beat(input cgb_pkg::res_t want, input cgb_pkg::res_t got,
                           input bit orphan);
    bad_beats++;
    if (bad_beats <= 10) begin
      if (orphan) begin
        $display("unexpected result beat: status %0d char %02h len %0d cursor %0d",
                 got.status, got.char_out, got.text_length, got.cursor_pos);
      end else begin
        $display("result mismatch: expected status %0d char %02h len %0d cursor %0d",
                 want.status, want.char_out, want.text_length, want.cursor_pos);
        $display("                 got      status %0d char %02h len %0d cursor %0d",
                 got.status, got.char_out, got.text_length, got.cursor_pos);
      end
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    cgb_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_beat('0, out_data, 1'b1);
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status || out_data.char_out !== want.char_out ||
            out_data.text_length !== want.text_length ||
            out_data.cursor_pos !== want.cursor_pos)
          flag_beat(want, out_data, 1'b0);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_cursor_text_gap_buffer_top NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stalls per beat, and one long hold-off so that the block backs up.
  initial begin
    int  n;
    bit  held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      n = draw_gap(rx_quiet);
      if (!held && results_taken >= HOLD_AT) begin
        held = 1'b1;
        n    = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    int guard;
    bad_beats     = 0;
    idle_cycles   = 0;
    items_sent    = 0;
    results_taken = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    head_cnt      = 0;
    tail_cnt      = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // Edge cases on the empty buffer and on a short text; typed rows are plain to read off.
    add_row(mk_row(cgb_pkg::OP_LEFT,   8'h00, 10'd0,   1, cgb_pkg::ST_EDGE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_RIGHT,  8'h00, 10'd0,   1, cgb_pkg::ST_EDGE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_BACK,   8'hFF, 10'd0,   1, cgb_pkg::ST_EDGE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd0,   1, cgb_pkg::ST_RANGE, 8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_READ,   8'hFF, 10'h3FF, 1, cgb_pkg::ST_RANGE, 8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_INSERT, 8'hFF, 10'h3FF, 1, cgb_pkg::ST_DONE,  8'h00, 1, 1));
    add_row(mk_row(cgb_pkg::OP_INSERT, 8'h00, 10'd0,   1, cgb_pkg::ST_DONE,  8'h00, 2, 2));
    add_row(mk_row(cgb_pkg::OP_INSERT, 8'h5A, 10'd0,   1, cgb_pkg::ST_DONE,  8'h00, 3, 3));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd0,   1, cgb_pkg::ST_DONE,  8'hFF, 3, 3));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd3,   1, cgb_pkg::ST_RANGE, 8'h00, 3, 3));
    add_row(mk_row(cgb_pkg::OP_LEFT,   8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_LEFT,   8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd1,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd2,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_INSERT, "P",   10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_LEFT,   8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_LEFT,   8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_BACK,   8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_RIGHT,  8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_RIGHT,  8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_RIGHT,  8'h00, 10'd0,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(OP_SPARE_LO,        8'hFF, 10'h3FF, 0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(OP_SPARE_MID,       8'hA5, 10'h155, 0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(OP_SPARE_HI,        8'h5A, 10'h2AA, 0, cgb_pkg::ST_DONE,  8'h00, 0, 0));
    add_row(mk_row(cgb_pkg::OP_READ,   8'h00, 10'd2,   0, cgb_pkg::ST_DONE,  8'h00, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i])
      send_cmd(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);

    // Mixed editing around a short text, with the cursor often hitting both ends.
    repeat (300) send_random(35, 15, 15, 15, 17);

    // Insert-heavy session until the buffer is full.
    guard = 0;
    while (head_cnt + tail_cnt < CAP && guard < 3000) begin
      send_random(88, 3, 3, 1, 5);
      guard++;
    end

    // Work on the full buffer: rejected inserts, moves and reads up to the last position.
    repeat (120) send_random(40, 15, 15, 2, 25);

    // Mixed editing for the rest of the run.
    while (items_sent < TOTAL_ITEMS) send_random(30, 15, 15, 20, 17);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (bad_beats == 0) begin
      $display("tb_cursor_text_gap_buffer_top OK");
    end else begin
      $display("tb_cursor_text_gap_buffer_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cgb_pkg.sv
rtl/cgb_ctrl.sv
rtl/cgb_dpath.sv
rtl/cursor_text_gap_buffer_top.sv
dv/tb_cursor_text_gap_buffer_top.sv
